// ----- rtl/core/csc_pkg.sv -----
// Shared types, constants and helpers for the cross-spectrum coherence block.
package csc_pkg;

	localparam int MAX_FREQS    = 64;
	localparam int MAX_BINS     = 64;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ACC_WIDTH    = 48;
	localparam int FREQ_W       = 6;
	localparam int BIN_W        = 6;
	localparam int ADDR_W       = FREQ_W + BIN_W;
	localparam int DEPTH        = MAX_FREQS * MAX_BINS;
	localparam int CNT_W        = 7;
	localparam int PROD_W       = 2 * SAMPLE_WIDTH + 1;
	localparam int SUM_W        = 64;
	localparam int WIDE_W       = 128;
	localparam int COH_W        = 16;
	localparam int TRIAL_W      = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 9;

	typedef enum logic [1:0] {
		CMD_ACC   = 2'd0,
		CMD_TRIAL = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FREQ_COUNT    = 3'd0,
		REG_BIN_COUNT     = 3'd1,
		REG_POOL_TAPERS   = 3'd2,
		REG_CHANNEL_COUNT = 3'd3,
		REG_SMOOTH_TIME   = 3'd4,
		REG_SMOOTH_FREQ   = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_DECODE, ST_CLEAR, ST_ACC_RD, ST_ACC_WR, ST_TRIAL,
		ST_Q_INIT, ST_Q_RD, ST_Q_SUM, ST_Q_MAG, ST_Q_MUL, ST_Q_CMP, ST_Q_DIV, ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_LOAD, OP_CLEAR, OP_ACC_RD, OP_ACC_WR, OP_TRIAL, OP_Q_INIT,
		OP_Q_RD, OP_Q_SUM, OP_Q_MAG, OP_Q_MUL, OP_Q_CMP, OP_Q_DIV, OP_OUT
	} op_t;

	typedef struct packed {
		cmd_t cmd;
		logic reject;
		logic no_trials;
		logic sweep_last;
		logic win_last;
		logic mul_last;
		logic div_last;
		logic early;
	} dp_stat_t;

	typedef struct packed {
		logic signed [ACC_WIDTH-1:0] cr;
		logic signed [ACC_WIDTH-1:0] ci;
		logic signed [ACC_WIDTH-1:0] pa;
		logic signed [ACC_WIDTH-1:0] pb;
	} entry_t;

	// saturating add of a product sum into a table entry
	function automatic logic signed [ACC_WIDTH-1:0] acc_sat(
		input logic signed [ACC_WIDTH-1:0] e,
		input logic signed [PROD_W-1:0] d
	);
		logic signed [ACC_WIDTH:0] s;
		s = (ACC_WIDTH+1)'(e) + (ACC_WIDTH+1)'(d);
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
			return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
				: {1'b0, {(ACC_WIDTH-1){1'b1}}};
		return s[ACC_WIDTH-1:0];
	endfunction

endpackage

// ----- rtl/core/csc_if.sv -----
// Channel interfaces: input items, result items and configuration writes.
interface csc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            command;
	logic [csc_pkg::FREQ_W-1:0]            freq_index;
	logic [csc_pkg::BIN_W-1:0]             bin_index;
	logic signed [csc_pkg::SAMPLE_WIDTH-1:0] a_re;
	logic signed [csc_pkg::SAMPLE_WIDTH-1:0] a_im;
	logic signed [csc_pkg::SAMPLE_WIDTH-1:0] b_re;
	logic signed [csc_pkg::SAMPLE_WIDTH-1:0] b_im;
	logic [7:0]                            chan_a;
	logic [7:0]                            chan_b;
	modport source (output valid, command, freq_index, bin_index, a_re, a_im, b_re, b_im,
		chan_a, chan_b, input ready);
	modport sink (input valid, command, freq_index, bin_index, a_re, a_im, b_re, b_im,
		chan_a, chan_b, output ready);
endinterface

interface csc_out_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic [csc_pkg::COH_W-1:0]     coherence;
	logic [csc_pkg::TRIAL_W-1:0]   trials;
	modport source (output valid, status, coherence, trials, input ready);
	modport sink (input valid, status, coherence, trials, output ready);
endinterface

interface csc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [csc_pkg::CFG_IDX_W-1:0]    index;
	logic [csc_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/csc_ctrl.sv -----
// Controller state machine sequencing the datapath for each command.
module csc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  csc_pkg::dp_stat_t   stat,
	output csc_pkg::op_t        op
);

	csc_pkg::state_t state_q, state_d;
	logic out_valid_q;

	assign out_valid = out_valid_q;

	// state and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csc_pkg::ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == csc_pkg::OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and datapath operation
	always_comb begin
		state_d  = state_q;
		op       = csc_pkg::OP_NOP;
		in_ready = 1'b0;
		case (state_q)
			csc_pkg::ST_INIT: begin
				op = csc_pkg::OP_CLEAR;
				if (stat.sweep_last) state_d = csc_pkg::ST_IDLE;
			end
			csc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = csc_pkg::OP_LOAD;
					state_d = csc_pkg::ST_DECODE;
				end
			end
			csc_pkg::ST_DECODE: begin
				case (stat.cmd)
					csc_pkg::CMD_ACC:
						state_d = stat.reject ? csc_pkg::ST_FINISH : csc_pkg::ST_ACC_RD;
					csc_pkg::CMD_TRIAL: state_d = csc_pkg::ST_TRIAL;
					csc_pkg::CMD_CLEAR: state_d = csc_pkg::ST_CLEAR;
					default:
						state_d = (stat.reject || stat.no_trials) ? csc_pkg::ST_FINISH
							: csc_pkg::ST_Q_INIT;
				endcase
			end
			csc_pkg::ST_CLEAR: begin
				op = csc_pkg::OP_CLEAR;
				if (stat.sweep_last) state_d = csc_pkg::ST_FINISH;
			end
			csc_pkg::ST_ACC_RD: begin
				op      = csc_pkg::OP_ACC_RD;
				state_d = csc_pkg::ST_ACC_WR;
			end
			csc_pkg::ST_ACC_WR: begin
				op      = csc_pkg::OP_ACC_WR;
				state_d = csc_pkg::ST_FINISH;
			end
			csc_pkg::ST_TRIAL: begin
				op      = csc_pkg::OP_TRIAL;
				state_d = csc_pkg::ST_FINISH;
			end
			csc_pkg::ST_Q_INIT: begin
				op      = csc_pkg::OP_Q_INIT;
				state_d = csc_pkg::ST_Q_RD;
			end
			csc_pkg::ST_Q_RD: begin
				op      = csc_pkg::OP_Q_RD;
				state_d = csc_pkg::ST_Q_SUM;
			end
			csc_pkg::ST_Q_SUM: begin
				op      = csc_pkg::OP_Q_SUM;
				state_d = stat.win_last ? csc_pkg::ST_Q_MAG : csc_pkg::ST_Q_RD;
			end
			csc_pkg::ST_Q_MAG: begin
				op      = csc_pkg::OP_Q_MAG;
				state_d = csc_pkg::ST_Q_MUL;
			end
			csc_pkg::ST_Q_MUL: begin
				op = csc_pkg::OP_Q_MUL;
				if (stat.mul_last) state_d = csc_pkg::ST_Q_CMP;
			end
			csc_pkg::ST_Q_CMP: begin
				op      = csc_pkg::OP_Q_CMP;
				state_d = stat.early ? csc_pkg::ST_FINISH : csc_pkg::ST_Q_DIV;
			end
			csc_pkg::ST_Q_DIV: begin
				op = csc_pkg::OP_Q_DIV;
				if (stat.div_last) state_d = csc_pkg::ST_FINISH;
			end
			csc_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					op      = csc_pkg::OP_OUT;
					state_d = csc_pkg::ST_IDLE;
				end
			end
			default: state_d = csc_pkg::ST_INIT;
		endcase
	end

endmodule

// ----- rtl/core/csc_dp.sv -----
// Datapath: config registers, spectral table, window sum, multiplier and divider.
module csc_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  csc_pkg::op_t                           op,
	output csc_pkg::dp_stat_t                      stat,
	input  logic                                   cfg_we,
	input  logic [csc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [csc_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic [1:0]                             in_command,
	input  logic [csc_pkg::FREQ_W-1:0]             in_freq,
	input  logic [csc_pkg::BIN_W-1:0]              in_bin,
	input  logic signed [csc_pkg::SAMPLE_WIDTH-1:0] in_a_re,
	input  logic signed [csc_pkg::SAMPLE_WIDTH-1:0] in_a_im,
	input  logic signed [csc_pkg::SAMPLE_WIDTH-1:0] in_b_re,
	input  logic signed [csc_pkg::SAMPLE_WIDTH-1:0] in_b_im,
	input  logic [7:0]                             in_chan_a,
	input  logic [7:0]                             in_chan_b,
	output logic                                   out_status,
	output logic [csc_pkg::COH_W-1:0]              out_coherence,
	output logic [csc_pkg::TRIAL_W-1:0]            out_trials
);

	localparam int CW = csc_pkg::CNT_W;
	localparam int FW = csc_pkg::FREQ_W;
	localparam int BW = csc_pkg::BIN_W;
	localparam int SW = csc_pkg::SUM_W;
	localparam int WW = csc_pkg::WIDE_W;

	// configuration
	logic [CW-1:0] freq_count_q, bin_count_q;
	logic          pool_q;
	logic [8:0]    chan_count_q;
	logic [2:0]    smooth_time_q, smooth_freq_q;

	// captured item
	csc_pkg::cmd_t cmd_q;
	logic [FW-1:0] f_q;
	logic [BW-1:0] b_q;
	logic signed [csc_pkg::SAMPLE_WIDTH-1:0] ar_q, ai_q, br_q, bi_q;
	logic reject_q;

	logic [csc_pkg::TRIAL_W-1:0] trial_q;
	logic [csc_pkg::ADDR_W-1:0]  clr_addr_q;

	// table
	csc_pkg::entry_t mem [csc_pkg::DEPTH];
	csc_pkg::entry_t rdata_q, wdata;
	logic mem_we, mem_re;
	logic [csc_pkg::ADDR_W-1:0] raddr, waddr, acc_addr;

	logic signed [csc_pkg::PROD_W-1:0] pcr_q, pci_q, ppa_q, ppb_q;

	// window walk and sums
	logic [FW-1:0] wi_q, f1_q;
	logic [BW-1:0] wj_q, b0_q, b1_q;
	logic signed [SW-1:0] s_cr_q, s_ci_q, s_pa_q, s_pb_q;
	logic [SW-1:0] m_cr_q, m_ci_q;
	logic zero_q;

	// multiplier and divider
	logic [4:0]    mul_cnt_q;
	logic [63:0]   prod_q;
	logic [WW-1:0] num_q, den_q, rem_q;
	logic [3:0]    div_cnt_q;
	logic          res_status_q;
	logic [csc_pkg::COH_W-1:0] res_coh_q;

	// effective counts and range checks
	logic [CW-1:0] eff_f, eff_b;
	logic acc_rej, q_rej;
	always_comb begin
		if (freq_count_q == '0) eff_f = CW'(1);
		else if (freq_count_q > CW'(csc_pkg::MAX_FREQS)) eff_f = CW'(csc_pkg::MAX_FREQS);
		else eff_f = freq_count_q;
		if (pool_q || bin_count_q == '0) eff_b = CW'(1);
		else if (bin_count_q > CW'(csc_pkg::MAX_BINS)) eff_b = CW'(csc_pkg::MAX_BINS);
		else eff_b = bin_count_q;
		acc_rej = ({1'b0, in_freq} >= eff_f) || ({1'b0, in_chan_a} >= chan_count_q)
			|| ({1'b0, in_chan_b} >= chan_count_q) || (!pool_q && {1'b0, in_bin} >= eff_b);
		q_rej = ({1'b0, in_freq} >= eff_f) || ({1'b0, in_bin} >= eff_b);
	end

	// window bounds
	logic [FW-1:0] f0_d, f1_d;
	logic [BW-1:0] b0_d, b1_d;
	logic [CW-1:0] f_hi, b_hi, ef_m1, eb_m1;
	always_comb begin
		f0_d  = (f_q >= FW'(smooth_freq_q)) ? f_q - FW'(smooth_freq_q) : '0;
		b0_d  = (b_q >= BW'(smooth_time_q)) ? b_q - BW'(smooth_time_q) : '0;
		f_hi  = {1'b0, f_q} + CW'(smooth_freq_q);
		b_hi  = {1'b0, b_q} + CW'(smooth_time_q);
		ef_m1 = eff_f - CW'(1);
		eb_m1 = eff_b - CW'(1);
		f1_d  = (f_hi > ef_m1) ? ef_m1[FW-1:0] : f_hi[FW-1:0];
		b1_d  = (b_hi > eb_m1) ? eb_m1[BW-1:0] : b_hi[BW-1:0];
	end

	// multiplier operand selection
	logic [3:0]  mstep;
	logic [1:0]  mjob;
	logic [31:0] opa, opb;
	logic [63:0] ja, jb;
	logic [WW-1:0] addend;
	always_comb begin
		mstep = mul_cnt_q[4:1];
		mjob  = mstep[3:2];
		case (mjob)
			2'd0: begin ja = m_cr_q; jb = m_cr_q; end
			2'd1: begin ja = m_ci_q; jb = m_ci_q; end
			default: begin ja = s_pa_q; jb = s_pb_q; end
		endcase
		opa = mstep[1] ? ja[63:32] : ja[31:0];
		opb = mstep[0] ? jb[63:32] : jb[31:0];
		case ({1'b0, mstep[1]} + {1'b0, mstep[0]})
			2'd0:    addend = WW'(prod_q);
			2'd1:    addend = WW'(prod_q) << 32;
			default: addend = WW'(prod_q) << 64;
		endcase
	end

	// divider step
	logic [WW-1:0] rem_sh;
	logic          q_bit;
	assign rem_sh = {rem_q[WW-2:0], 1'b0};
	assign q_bit  = rem_sh >= den_q;

	// status to controller
	assign stat.cmd        = cmd_q;
	assign stat.reject     = reject_q;
	assign stat.no_trials  = (trial_q == '0);
	assign stat.sweep_last = (clr_addr_q == '1);
	assign stat.win_last   = (wi_q == f1_q) && (wj_q == b1_q);
	assign stat.mul_last   = (mul_cnt_q == 5'd23);
	assign stat.div_last   = (div_cnt_q == '1);
	assign stat.early      = zero_q || (num_q >= den_q);

	// table ports
	assign acc_addr = {f_q, pool_q ? {BW{1'b0}} : b_q};
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr  = acc_addr;
		raddr  = acc_addr;
		wdata  = '0;
		case (op)
			csc_pkg::OP_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_addr_q;
			end
			csc_pkg::OP_ACC_RD: mem_re = 1'b1;
			csc_pkg::OP_ACC_WR: begin
				mem_we   = 1'b1;
				wdata.cr = csc_pkg::acc_sat(rdata_q.cr, pcr_q);
				wdata.ci = csc_pkg::acc_sat(rdata_q.ci, pci_q);
				wdata.pa = csc_pkg::acc_sat(rdata_q.pa, ppa_q);
				wdata.pb = csc_pkg::acc_sat(rdata_q.pb, ppb_q);
			end
			csc_pkg::OP_Q_RD: begin
				mem_re = 1'b1;
				raddr  = {wi_q, wj_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rdata_q <= mem[raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_count_q  <= CW'(csc_pkg::MAX_FREQS);
			bin_count_q   <= CW'(csc_pkg::MAX_BINS);
			pool_q        <= 1'b0;
			chan_count_q  <= 9'd256;
			smooth_time_q <= '0;
			smooth_freq_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				csc_pkg::REG_FREQ_COUNT:    freq_count_q  <= cfg_data[CW-1:0];
				csc_pkg::REG_BIN_COUNT:     bin_count_q   <= cfg_data[CW-1:0];
				csc_pkg::REG_POOL_TAPERS:   pool_q        <= cfg_data[0];
				csc_pkg::REG_CHANNEL_COUNT: chan_count_q  <= cfg_data;
				csc_pkg::REG_SMOOTH_TIME:   smooth_time_q <= cfg_data[2:0];
				csc_pkg::REG_SMOOTH_FREQ:   smooth_freq_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trial_q    <= '0;
			clr_addr_q <= '0;
			cmd_q      <= csc_pkg::CMD_ACC;
			reject_q   <= 1'b0;
		end else begin
			case (op)
				csc_pkg::OP_LOAD: begin
					cmd_q <= csc_pkg::cmd_t'(in_command);
					case (csc_pkg::cmd_t'(in_command))
						csc_pkg::CMD_ACC:   reject_q <= acc_rej;
						csc_pkg::CMD_QUERY: reject_q <= q_rej;
						default:            reject_q <= 1'b0;
					endcase
				end
				csc_pkg::OP_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					trial_q    <= '0;
				end
				csc_pkg::OP_TRIAL: if (trial_q != '1) trial_q <= trial_q + 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			csc_pkg::OP_LOAD: begin
				f_q  <= in_freq;
				b_q  <= in_bin;
				ar_q <= in_a_re;
				ai_q <= in_a_im;
				br_q <= in_b_re;
				bi_q <= in_b_im;
				res_coh_q <= '0;
				case (csc_pkg::cmd_t'(in_command))
					csc_pkg::CMD_ACC:   res_status_q <= acc_rej;
					csc_pkg::CMD_QUERY: res_status_q <= q_rej;
					default:            res_status_q <= 1'b0;
				endcase
			end
			csc_pkg::OP_ACC_RD: begin
				pcr_q <= csc_pkg::PROD_W'(ar_q * br_q) + csc_pkg::PROD_W'(ai_q * bi_q);
				pci_q <= csc_pkg::PROD_W'(ai_q * br_q) - csc_pkg::PROD_W'(ar_q * bi_q);
				ppa_q <= csc_pkg::PROD_W'(ar_q * ar_q) + csc_pkg::PROD_W'(ai_q * ai_q);
				ppb_q <= csc_pkg::PROD_W'(br_q * br_q) + csc_pkg::PROD_W'(bi_q * bi_q);
			end
			csc_pkg::OP_Q_INIT: begin
				wi_q   <= f0_d;
				wj_q   <= b0_d;
				b0_q   <= b0_d;
				f1_q   <= f1_d;
				b1_q   <= b1_d;
				s_cr_q <= '0;
				s_ci_q <= '0;
				s_pa_q <= '0;
				s_pb_q <= '0;
			end
			csc_pkg::OP_Q_SUM: begin
				// window sums stay far below the 64-bit limit
				s_cr_q <= s_cr_q + SW'(rdata_q.cr);
				s_ci_q <= s_ci_q + SW'(rdata_q.ci);
				s_pa_q <= s_pa_q + SW'(rdata_q.pa);
				s_pb_q <= s_pb_q + SW'(rdata_q.pb);
				if (wj_q == b1_q) begin
					wj_q <= b0_q;
					wi_q <= wi_q + 1'b1;
				end else begin
					wj_q <= wj_q + 1'b1;
				end
			end
			csc_pkg::OP_Q_MAG: begin
				m_cr_q    <= s_cr_q[SW-1] ? SW'(-s_cr_q) : SW'(s_cr_q);
				m_ci_q    <= s_ci_q[SW-1] ? SW'(-s_ci_q) : SW'(s_ci_q);
				zero_q    <= (s_pa_q <= 0) || (s_pb_q <= 0);
				num_q     <= '0;
				den_q     <= '0;
				mul_cnt_q <= '0;
			end
			csc_pkg::OP_Q_MUL: begin
				// even step multiplies one partial product, odd step adds it in
				mul_cnt_q <= mul_cnt_q + 1'b1;
				if (!mul_cnt_q[0]) prod_q <= opa * opb;
				else if (mjob == 2'd2) den_q <= den_q + addend;
				else num_q <= num_q + addend;
			end
			csc_pkg::OP_Q_CMP: begin
				rem_q     <= num_q;
				div_cnt_q <= '0;
				if (zero_q) res_coh_q <= '0;
				else if (num_q >= den_q) res_coh_q <= '1;
				else res_coh_q <= '0;
			end
			csc_pkg::OP_Q_DIV: begin
				div_cnt_q <= div_cnt_q + 1'b1;
				rem_q     <= q_bit ? rem_sh - den_q : rem_sh;
				res_coh_q <= {res_coh_q[csc_pkg::COH_W-2:0], q_bit};
			end
			csc_pkg::OP_OUT: begin
				out_status    <= res_status_q;
				out_coherence <= res_coh_q;
				out_trials    <= trial_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/cross_spectrum_coherence.sv -----
// Top level of the cross-spectrum coherence accumulator.
// Input channel in_ch carries one command per transfer: accumulate a coefficient pair,
// end a trial, clear the table, or query the coherence at a frequency and bin.
// Every command returns exactly one result transfer on out_ch (status, coherence,
// trials). Configuration writes arrive on cfg_ch, always ready; the user must send them
// only while the block is idle, as the block itself does not enforce this.
// Items are handled one at a time by the controller. An accumulate reads its table
// entry and writes back the saturated sums; a clear writes one table row per cycle; a
// query makes one table read then one add for each window entry, then runs the shared
// 32x32 multiplier and 16 divider steps. Rejected commands and queries with no trials
// skip all table work; a query whose ratio reaches one or whose power sum is zero
// skips the divider.
// The block is ready for the next input in the cycle after the result is loaded.
// After reset the table is swept to zero, during which in_ch is not
// ready; config writes are still taken. The result register holds its transfer
// while out_ch.ready is low; the block then accepts the next command but does not
// finish it until the result register is free.
module cross_spectrum_coherence (
	input logic          clk,
	input logic          arst_n,
	csc_in_if.sink       in_ch,
	csc_out_if.source    out_ch,
	csc_cfg_if.sink      cfg_ch
);

	csc_pkg::op_t      op;
	csc_pkg::dp_stat_t stat;

	assign cfg_ch.ready = 1'b1;

	csc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.stat      (stat),
		.op        (op)
	);

	csc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.stat          (stat),
		.cfg_we        (cfg_ch.valid),
		.cfg_index     (cfg_ch.index),
		.cfg_data      (cfg_ch.data),
		.in_command    (in_ch.command),
		.in_freq       (in_ch.freq_index),
		.in_bin        (in_ch.bin_index),
		.in_a_re       (in_ch.a_re),
		.in_a_im       (in_ch.a_im),
		.in_b_re       (in_ch.b_re),
		.in_b_im       (in_ch.b_im),
		.in_chan_a     (in_ch.chan_a),
		.in_chan_b     (in_ch.chan_b),
		.out_status    (out_ch.status),
		.out_coherence (out_ch.coherence),
		.out_trials    (out_ch.trials)
	);

endmodule

// ----- rtl/core/csc_checker.sv -----
// Port-level assertions for the coherence block and their bind to the top level.
module csc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_status,
	input logic [15:0] out_coherence,
	input logic [15:0] out_trials
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_coherence) && $stable(out_trials)
			&& $stable(out_status))
		else $error("result payload changed while stalled");

	// rejected commands never carry a coherence value
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status |-> out_coherence == 16'd0)
		else $error("rejected command with nonzero coherence");

	// one command at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a command is in flight");

	// no result appears in the cycle right after an input transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind cross_spectrum_coherence csc_checker u_csc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_status    (out_ch.status),
	.out_coherence (out_ch.coherence),
	.out_trials    (out_ch.trials)
);

// ----- tb/cross_spectrum_coherence_tb.sv -----
// Self-checking testbench for the cross-spectrum coherence accumulator.
`timescale 1ns / 100ps

module cross_spectrum_coherence_tb;

	// unmapped register index, writes must be ignored
	localparam logic [csc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
	localparam int IDLE_TAIL = 16;

	typedef struct {
		csc_pkg::cmd_t                           cmd;
		logic [csc_pkg::FREQ_W-1:0]              f;
		logic [csc_pkg::BIN_W-1:0]               b;
		logic signed [csc_pkg::SAMPLE_WIDTH-1:0] ar, ai, br, bi;
		logic [7:0]                              ca, cb;
	} spec_item_t;

	typedef struct {
		logic                         status;
		logic [csc_pkg::COH_W-1:0]    coh;
		logic [csc_pkg::TRIAL_W-1:0]  trials;
	} coh_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	csc_in_if  in_ch();
	csc_out_if out_ch();
	csc_cfg_if cfg_ch();

	cross_spectrum_coherence DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always #5 clk = ~clk;

	// shadow table and settings
	longint xre_tab[csc_pkg::DEPTH], xim_tab[csc_pkg::DEPTH];
	longint pwa_tab[csc_pkg::DEPTH], pwb_tab[csc_pkg::DEPTH];
	int unsigned trial_cnt;
	int unsigned m_freqs, m_bins, m_pool, m_chans, m_st, m_sf;

	coh_result_t pending_q[$];
	int unsigned send_idle_pct = 0, recv_stall_pct = 0;
	int unsigned hold_req = 0;
	int unsigned mismatches = 0, n_sent = 0, n_queries = 0, n_rejects = 0, n_nonzero = 0;

	function automatic longint sat_range(longint a, longint d, longint hi, longint lo);
		logic signed [64:0] s;
		s = 65'(signed'(a)) + 65'(signed'(d));
		if (s > 65'(signed'(hi))) return hi;
		if (s < 65'(signed'(lo))) return lo;
		return longint'(s);
	endfunction

	function automatic longint entry_add(longint e, longint d);
		longint hi;
		hi = (longint'(1) <<< (csc_pkg::ACC_WIDTH - 1)) - 1;
		return sat_range(e, d, hi, -hi - 1);
	endfunction

	function automatic int unsigned eff_freqs();
		return (m_freqs < 1) ? 1
			: (m_freqs > csc_pkg::MAX_FREQS ? csc_pkg::MAX_FREQS : m_freqs);
	endfunction

	function automatic int unsigned eff_bins();
		if (m_pool != 0 || m_bins < 1) return 1;
		return m_bins > csc_pkg::MAX_BINS ? csc_pkg::MAX_BINS : m_bins;
	endfunction

	// windowed magnitude-squared coherence in Q0.16
	function automatic logic [csc_pkg::COH_W-1:0] window_coherence(int f, int b);
		int f0, f1, b0, b1, idx;
		longint cr, ci, pa, pb;
		logic [63:0] mcr, mci;
		logic [127:0] num, den;
		logic [143:0] q;
		f0 = f - int'(m_sf); f1 = f + int'(m_sf);
		b0 = b - int'(m_st); b1 = b + int'(m_st);
		if (f0 < 0) f0 = 0;
		if (f1 > int'(eff_freqs()) - 1) f1 = int'(eff_freqs()) - 1;
		if (b0 < 0) b0 = 0;
		if (b1 > int'(eff_bins()) - 1) b1 = int'(eff_bins()) - 1;
		cr = 0; ci = 0; pa = 0; pb = 0;
		for (int i = f0; i <= f1; i++)
			for (int j = b0; j <= b1; j++) begin
				idx = i * csc_pkg::MAX_BINS + j;
				cr = sat_range(cr, xre_tab[idx], 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
				ci = sat_range(ci, xim_tab[idx], 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
				pa = sat_range(pa, pwa_tab[idx], 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
				pb = sat_range(pb, pwb_tab[idx], 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
			end
		if (pa <= 0 || pb <= 0) return '0;
		mcr = (cr < 0) ? -cr : cr;
		mci = (ci < 0) ? -ci : ci;
		num = {64'd0, mcr} * {64'd0, mcr} + {64'd0, mci} * {64'd0, mci};
		den = {64'd0, pa} * {64'd0, pb};
		if (num >= den) return 16'hFFFF;
		q = {num, 16'd0} / {16'd0, den};
		return q[15:0];
	endfunction

	// update the shadow state and produce the expected result
	function automatic coh_result_t model_item(spec_item_t it);
		coh_result_t r;
		int unsigned idx;
		longint ar, ai, br, bi;
		r.status = 1'b0; r.coh = '0;
		case (it.cmd)
			csc_pkg::CMD_ACC: begin
				if (it.f >= eff_freqs() || it.ca >= m_chans || it.cb >= m_chans
						|| (m_pool == 0 && it.b >= eff_bins())) begin
					r.status = 1'b1;
				end else begin
					ar = it.ar; ai = it.ai; br = it.br; bi = it.bi;
					idx = it.f * csc_pkg::MAX_BINS + (m_pool != 0 ? 0 : it.b);
					xre_tab[idx] = entry_add(xre_tab[idx], ar * br + ai * bi);
					xim_tab[idx] = entry_add(xim_tab[idx], ai * br - ar * bi);
					pwa_tab[idx] = entry_add(pwa_tab[idx], ar * ar + ai * ai);
					pwb_tab[idx] = entry_add(pwb_tab[idx], br * br + bi * bi);
				end
			end
			csc_pkg::CMD_TRIAL: if (trial_cnt < 65535) trial_cnt++;
			csc_pkg::CMD_CLEAR: begin
				for (int k = 0; k < csc_pkg::DEPTH; k++) begin
					xre_tab[k] = 0; xim_tab[k] = 0; pwa_tab[k] = 0; pwb_tab[k] = 0;
				end
				trial_cnt = 0;
			end
			default: begin
				if (it.f >= eff_freqs() || it.b >= eff_bins())
					r.status = 1'b1;
				else if (trial_cnt != 0)
					r.coh = window_coherence(int'(it.f), int'(it.b));
			end
		endcase
		r.trials = trial_cnt[csc_pkg::TRIAL_W-1:0];
		return r;
	endfunction

	// offer one item, with random idle beforehand; valid is left high
	task automatic send_item(spec_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= it.cmd;
		in_ch.freq_index <= it.f; in_ch.bin_index <= it.b;
		in_ch.a_re <= it.ar; in_ch.a_im <= it.ai;
		in_ch.b_re <= it.br; in_ch.b_im <= it.bi;
		in_ch.chan_a <= it.ca; in_ch.chan_b <= it.cb;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_q.push_back(model_item(it));
		n_sent++;
		if (it.cmd == csc_pkg::CMD_QUERY) n_queries++;
		if (pending_q[$].status) n_rejects++;
		if (pending_q[$].coh != 0) n_nonzero++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(logic [csc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val[csc_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			csc_pkg::REG_FREQ_COUNT:    m_freqs = val & 7'h7F;
			csc_pkg::REG_BIN_COUNT:     m_bins = val & 7'h7F;
			csc_pkg::REG_POOL_TAPERS:   m_pool = val & 1;
			csc_pkg::REG_CHANNEL_COUNT: m_chans = val & 9'h1FF;
			csc_pkg::REG_SMOOTH_TIME:   m_st = val & 7;
			csc_pkg::REG_SMOOTH_FREQ:   m_sf = val & 7;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(int unsigned fc, int unsigned bc, int unsigned pool,
			int unsigned ch, int unsigned st, int unsigned sf);
		write_reg(csc_pkg::REG_FREQ_COUNT, fc);
		write_reg(csc_pkg::REG_BIN_COUNT, bc);
		write_reg(csc_pkg::REG_POOL_TAPERS, pool);
		write_reg(csc_pkg::REG_CHANNEL_COUNT, ch);
		write_reg(csc_pkg::REG_SMOOTH_TIME, st);
		write_reg(csc_pkg::REG_SMOOTH_FREQ, sf);
	endtask

	function automatic spec_item_t make_item(csc_pkg::cmd_t c, int f, int b, int ar,
			int ai, int br, int bi, int ca, int cb);
		spec_item_t it;
		it.cmd = c;
		it.f = csc_pkg::FREQ_W'(f); it.b = csc_pkg::BIN_W'(b);
		it.ar = csc_pkg::SAMPLE_WIDTH'(ar); it.ai = csc_pkg::SAMPLE_WIDTH'(ai);
		it.br = csc_pkg::SAMPLE_WIDTH'(br); it.bi = csc_pkg::SAMPLE_WIDTH'(bi);
		it.ca = 8'(ca); it.cb = 8'(cb);
		return it;
	endfunction

	function automatic logic signed [csc_pkg::SAMPLE_WIDTH-1:0] rnd_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return csc_pkg::SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	// mostly well-formed accumulate/query traffic, some trial ends and noise, rare clears
	function automatic spec_item_t rnd_item();
		spec_item_t it;
		int unsigned p;
		it.cmd = csc_pkg::CMD_ACC;
		it.f = csc_pkg::FREQ_W'($urandom_range(eff_freqs() - 1));
		it.b = csc_pkg::BIN_W'($urandom_range((m_pool != 0) ? 63 : eff_bins() - 1));
		it.ar = rnd_sample(); it.ai = rnd_sample();
		it.br = rnd_sample(); it.bi = rnd_sample();
		it.ca = 8'($urandom_range(m_chans - 1)); it.cb = 8'($urandom_range(m_chans - 1));
		p = $urandom_range(99);
		if (p < 10) begin
			it.f = csc_pkg::FREQ_W'($urandom); it.b = csc_pkg::BIN_W'($urandom);
			it.ca = 8'($urandom); it.cb = 8'($urandom);
		end else if (p < 22) it.cmd = csc_pkg::CMD_TRIAL;
		else if (p < 24) it.cmd = csc_pkg::CMD_CLEAR;
		else if (p < 40) begin
			it.cmd = csc_pkg::CMD_QUERY;
			it.b = csc_pkg::BIN_W'($urandom_range(eff_bins() - 1));
		end else if (p < 43) begin
			it.cmd = csc_pkg::CMD_QUERY;
			it.f = csc_pkg::FREQ_W'($urandom); it.b = csc_pkg::BIN_W'($urandom);
		end
		return it;
	endfunction

	// result checker against the oldest expectation
	always @(posedge clk) begin
		coh_result_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected result: status %0b coh %0d trials %0d", $realtime,
						out_ch.status, out_ch.coherence, out_ch.trials);
			end else begin
				e = pending_q.pop_front();
				if (out_ch.status !== e.status || out_ch.coherence !== e.coh
						|| out_ch.trials !== e.trials) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t mismatch: exp status %0b coh %0d trials %0d, got %0b %0d %0d",
							$realtime, e.status, e.coh, e.trials,
							out_ch.status, out_ch.coherence, out_ch.trials);
				end
			end
		end
	end

	// result-side ready: random stalls plus requested long holds
	always @(posedge clk) begin
		int unsigned hold_left;
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// extremes, rejects, pooling, unmapped register, zero denominator
	task automatic test_directed();
		send_item(make_item(csc_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_ACC, 63, 63, -32768, -32768, -32768, -32768, 255, 255));
		send_item(make_item(csc_pkg::CMD_ACC, 63, 63, 32767, -32768, 0, 32767, 0, 255));
		send_item(make_item(csc_pkg::CMD_ACC, 0, 0, 32767, 32767, 32767, 32767, 0, 0));
		send_item(make_item(csc_pkg::CMD_ACC, 1, 0, 1000, 0, 0, 0, 7, 9));
		send_item(make_item(csc_pkg::CMD_QUERY, 63, 63, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_TRIAL, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_QUERY, 63, 63, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_QUERY, 1, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_QUERY, 20, 20, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_QUERY, 63, 63, 0, 0, 0, 0, 0, 0));
		drain();
		set_config(4, 4, 0, 2, 0, 0);
		write_reg(REG_UNMAPPED, 9'h1FF);
		send_item(make_item(csc_pkg::CMD_ACC, 4, 0, 5, 5, 5, 5, 0, 0));
		send_item(make_item(csc_pkg::CMD_ACC, 0, 4, 5, 5, 5, 5, 0, 0));
		send_item(make_item(csc_pkg::CMD_ACC, 0, 0, 5, 5, 5, 5, 2, 0));
		send_item(make_item(csc_pkg::CMD_ACC, 0, 0, 5, 5, 5, 5, 1, 255));
		send_item(make_item(csc_pkg::CMD_QUERY, 4, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_QUERY, 0, 4, 0, 0, 0, 0, 0, 0));
		drain();
		write_reg(csc_pkg::REG_POOL_TAPERS, 1);
		send_item(make_item(csc_pkg::CMD_ACC, 3, 63, 123, -77, 400, 9, 1, 1));
		send_item(make_item(csc_pkg::CMD_TRIAL, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_QUERY, 3, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(csc_pkg::CMD_QUERY, 3, 1, 0, 0, 0, 0, 0, 0));
		drain();
	endtask

	// random traffic under several settings and idle patterns
	task automatic test_random_phases();
		int unsigned fcs[4] = '{1, 64, 4, 7};
		int unsigned bcs[4] = '{64, 1, 5, 3};
		int unsigned pls[4] = '{0, 0, 1, 0};
		int unsigned chs[4] = '{256, 1, 200, 17};
		int unsigned sts[4] = '{0, 7, 3, 2};
		int unsigned sfs[4] = '{7, 0, 2, 5};
		int unsigned sidle[4] = '{0, 45, 0, 22};
		int unsigned rstall[4] = '{0, 0, 45, 22};
		for (int ph = 0; ph < 4; ph++) begin
			set_config(fcs[ph], bcs[ph], pls[ph], chs[ph], sts[ph], sfs[ph]);
			send_idle_pct = sidle[ph]; recv_stall_pct = rstall[ph];
			for (int k = 0; k < 190; k++) send_item(rnd_item());
			drain();
		end
	endtask

	// long receiver hold while the sender keeps offering, then a full pause and a second burst
	task automatic test_backpressure();
		set_config(8, 8, 0, 256, 1, 1);
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_req = 400;
		for (int k = 0; k < 40; k++) send_item(rnd_item());
		drain();
		for (int k = 0; k < 20; k++) send_item(rnd_item());
		drain();
	endtask

	initial begin
		in_ch.valid = 1'b0; in_ch.command = csc_pkg::CMD_ACC;
		in_ch.freq_index = '0; in_ch.bin_index = '0;
		in_ch.a_re = '0; in_ch.a_im = '0; in_ch.b_re = '0; in_ch.b_im = '0;
		in_ch.chan_a = '0; in_ch.chan_b = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0; cfg_ch.index = csc_pkg::REG_FREQ_COUNT; cfg_ch.data = '0;
		for (int k = 0; k < csc_pkg::DEPTH; k++) begin
			xre_tab[k] = 0; xim_tab[k] = 0; pwa_tab[k] = 0; pwb_tab[k] = 0;
		end
		trial_cnt = 0;
		m_freqs = 64; m_bins = 64; m_pool = 0; m_chans = 256; m_st = 0; m_sf = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phases();
		test_backpressure();

		drain();
		$display("Covered %0d commands (%0d queries, %0d rejects, %0d nonzero coherences)",
			n_sent, n_queries, n_rejects, n_nonzero);
		$display("with directed edge cases, four random setups and idle patterns, a long hold.");
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#200ms;
		$display("Timeout with %0d results outstanding", pending_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/csc_pkg.sv
rtl/core/csc_if.sv
rtl/core/csc_ctrl.sv
rtl/core/csc_dp.sv
rtl/core/cross_spectrum_coherence.sv
rtl/core/csc_checker.sv
tb/cross_spectrum_coherence_tb.sv
